FILE: design/svpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpd_pkg
// Shared types, widths and constants of the space vector pwm duty unit.
// ----------------------------------------------------------------------------
package svpd_pkg;

   localparam int SINE_TABLE_ENTRIES_DEFAULT = 512;

   localparam int ANGLE_W = 32;
   localparam int Q31_W   = 31;
   localparam int ALPHA_W = 30;
   localparam int ARG_W   = 29;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [ANGLE_W-1:0] SECTOR_SPAN   = 32'd715827883;
   localparam logic [Q31_W-1:0]   INV_ROOT3_Q31 = 31'd1239850262;
   localparam logic [Q31_W-1:0]   HALF_Q31      = 31'h40000000;

   localparam logic [ANGLE_W-1:0] SECTOR_BASE [6] = '{
      32'd0, 32'd715827883, 32'd1431655766,
      32'd2147483649, 32'd2863311532, 32'd3579139415
   };

   typedef enum logic [2:0] {
      SECTOR_0,
      SECTOR_1,
      SECTOR_2,
      SECTOR_3,
      SECTOR_4,
      SECTOR_5
   } svpd_sector_type;

   typedef struct packed {
      svpd_sector_type    sector;
      logic [ARG_W-1:0]   arg_a;
      logic [ARG_W-1:0]   arg_b;
      logic [Q31_W-1:0]   scale;
   } svpd_job_type;

   // table rows needed for sine arguments up to one sixth of a turn
   function automatic int rom_depth(input int entries);
      return entries / 6 + 2;
   endfunction

endpackage

FILE: design/space_vector_pwm_duty_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// space_vector_pwm_duty_unit
// Three-phase space vector pwm: angle and modulation in, center-aligned
// U, V, W duty values out.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | req_valid req_ready req_angle           | in
//           | req_modulation                          |
//   rsp     | rsp_valid rsp_ready rsp_duty_u/v/w      | out
//
// one transaction per cycle sustained while rsp_ready is high; from req accept
// to rsp_valid it passes the front register, the queue and six back stages:
// index, sine table read, interpolation, sine, vector time multiply, routing
// synchronous reset empties the front register, the queue and the back stages
// rsp_ready low with rsp_valid high freezes the back stages; the 4-entry queue
// and the front register keep taking them until full, then req_ready drops
// ----------------------------------------------------------------------------
module space_vector_pwm_duty_unit #(
   parameter int SINE_TABLE_ENTRIES = svpd_pkg::SINE_TABLE_ENTRIES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [svpd_pkg::ANGLE_W-1:0]   req_angle,
   input  logic [svpd_pkg::Q31_W-1:0]     req_modulation,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [svpd_pkg::Q31_W-1:0]     rsp_duty_u,
   output logic [svpd_pkg::Q31_W-1:0]     rsp_duty_v,
   output logic [svpd_pkg::Q31_W-1:0]     rsp_duty_w
);

   logic                     push_valid;
   svpd_pkg::svpd_job_type   push_job;
   logic                     queue_full;
   logic                     queue_empty;
   logic                     queue_pop;
   svpd_pkg::svpd_job_type   head_job;

   svpd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_angle      (req_angle),
      .req_modulation (req_modulation),
      .queue_full     (queue_full),
      .job_valid      (push_valid),
      .job            (push_job)
   );

   svpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_job),
      .full       (queue_full),
      .pop        (queue_pop),
      .empty      (queue_empty),
      .pop_data   (head_job)
   );

   svpd_back #(
      .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (!queue_empty),
      .job        (head_job),
      .job_pop    (queue_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_duty_u (rsp_duty_u),
      .rsp_duty_v (rsp_duty_v),
      .rsp_duty_w (rsp_duty_w)
   );

endmodule

FILE: design/svpd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpd_front
// Accepts angle and modulation, finds the sector, the in-sector angle and the
// scaled modulation, and hands a job to the queue.
// ----------------------------------------------------------------------------
module svpd_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [svpd_pkg::ANGLE_W-1:0]   req_angle,
   input  logic [svpd_pkg::Q31_W-1:0]     req_modulation,
   input  logic                           queue_full,
   output logic                           job_valid,
   output svpd_pkg::svpd_job_type         job
);

   localparam int PROD_W = 2 * svpd_pkg::Q31_W;

   logic                               valid_ff;
   logic                               valid_in;
   svpd_pkg::svpd_sector_type          sector_ff;
   svpd_pkg::svpd_sector_type          sector_in;
   logic [svpd_pkg::ALPHA_W-1:0]       alpha_ff;
   logic [svpd_pkg::ALPHA_W-1:0]       alpha_in;
   logic [PROD_W-1:0]                  product_ff;
   logic [PROD_W-1:0]                  product_in;
   logic [svpd_pkg::ANGLE_W-1:0]       base;
   logic [svpd_pkg::ANGLE_W-1:0]       diff;
   logic [svpd_pkg::ALPHA_W-1:0]       span_rest;
   logic                               take;

   always_comb begin
      req_ready = !valid_ff || !queue_full;
      take      = req_valid && req_ready;
      if (take) begin
         valid_in = 1'b1;
      end else begin
         valid_in = valid_ff && queue_full;
      end

      sector_in = svpd_pkg::SECTOR_0;
      base      = svpd_pkg::SECTOR_BASE[0];
      for (int k = 1; k < 6; k++) begin
         if (req_angle >= svpd_pkg::SECTOR_BASE[k]) begin
            sector_in = svpd_pkg::svpd_sector_type'(3'(k));
            base      = svpd_pkg::SECTOR_BASE[k];
         end
      end
      diff       = req_angle - base;
      alpha_in   = diff[svpd_pkg::ALPHA_W-1:0];
      product_in = {{svpd_pkg::Q31_W{1'b0}}, req_modulation}
                 * {{svpd_pkg::Q31_W{1'b0}}, svpd_pkg::INV_ROOT3_Q31};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sector_ff  <= sector_in;
         alpha_ff   <= alpha_in;
         product_ff <= product_in;
      end
   end

   always_comb begin
      span_rest  = svpd_pkg::SECTOR_SPAN[svpd_pkg::ALPHA_W-1:0] - alpha_ff;
      job_valid  = valid_ff;
      job.sector = sector_ff;
      job.arg_a  = span_rest[svpd_pkg::ALPHA_W-1:1];
      job.arg_b  = alpha_ff[svpd_pkg::ALPHA_W-1:1];
      job.scale  = product_ff[PROD_W-1:svpd_pkg::Q31_W];
   end

endmodule

FILE: design/svpd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpd_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module svpd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  svpd_pkg::svpd_job_type    push_data,
   output logic                      full,
   input  logic                      pop,
   output logic                      empty,
   output svpd_pkg::svpd_job_type    pop_data
);

   localparam int DEPTH = svpd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   svpd_pkg::svpd_job_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff;
   logic [PTR_W-1:0]         wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff;
   logic [PTR_W-1:0]         rd_ptr_in;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     push;

   always_comb begin
      full     = (count_ff == CNT_W'(DEPTH));
      empty    = (count_ff == '0);
      push     = push_valid && !full;
      pop_data = mem_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      if (push) begin
         if (wr_ptr_ff == PTR_W'(DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end

      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         if (rd_ptr_ff == PTR_W'(DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end

      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/svpd_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpd_sine_rom
// Sine table over the first sixth of a turn, two neighboring rows read per
// cycle while enabled, registered outputs. Contents are built at elaboration.
// ----------------------------------------------------------------------------
module svpd_sine_rom #(
   parameter  int SINE_TABLE_ENTRIES = svpd_pkg::SINE_TABLE_ENTRIES_DEFAULT,
   localparam int ROM_DEPTH          = svpd_pkg::rom_depth(SINE_TABLE_ENTRIES),
   localparam int ADDR_W             = $clog2(ROM_DEPTH)
) (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [ADDR_W-1:0]           addr,
   output logic [svpd_pkg::Q31_W-1:0]  data_lo,
   output logic [svpd_pkg::Q31_W-1:0]  data_hi
);

   localparam logic [63:0] ENTRIES        = 64'(SINE_TABLE_ENTRIES);
   localparam logic [63:0] QUARTER_PI_Q62 = 64'h3243F6A8885A308D;
   localparam logic [63:0] ONE_Q62        = 64'h4000000000000000;

   typedef logic [svpd_pkg::Q31_W-1:0] rom_array_type [ROM_DEPTH];

   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   function automatic logic [63:0] div_term(input logic [63:0] x, input int n,
                                            input logic use_cos);
      logic [63:0] q;
      q = x;
      if (use_cos) begin
         case (n)
            1:       q = x / 64'd2;
            2:       q = x / 64'd12;
            3:       q = x / 64'd30;
            4:       q = x / 64'd56;
            5:       q = x / 64'd90;
            6:       q = x / 64'd132;
            7:       q = x / 64'd182;
            8:       q = x / 64'd240;
            9:       q = x / 64'd306;
            10:      q = x / 64'd380;
            11:      q = x / 64'd462;
            default: q = x;
         endcase
      end else begin
         case (n)
            1:       q = x / 64'd6;
            2:       q = x / 64'd20;
            3:       q = x / 64'd42;
            4:       q = x / 64'd72;
            5:       q = x / 64'd110;
            6:       q = x / 64'd156;
            7:       q = x / 64'd210;
            8:       q = x / 64'd272;
            9:       q = x / 64'd342;
            10:      q = x / 64'd420;
            11:      q = x / 64'd506;
            default: q = x;
         endcase
      end
      return q;
   endfunction

   function automatic logic [63:0] series_q62(input logic [63:0] t, input logic use_cos);
      logic [63:0] t2;
      logic [63:0] term;
      logic [63:0] sum;
      t2   = mul_q62(t, t);
      term = use_cos ? ONE_Q62 : t;
      sum  = term;
      for (int n = 1; n <= 11; n++) begin
         term = div_term(mul_q62(term, t2), n, use_cos);
         if ((n & 1) != 0) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   function automatic rom_array_type build_rom();
      rom_array_type rom;
      logic [63:0]   e;
      logic [63:0]   oct;
      logic [63:0]   rem;
      logic [63:0]   q;
      logic [63:0]   t;
      logic [63:0]   v;
      logic          use_cos;
      for (int k = 0; k < ROM_DEPTH; k++) begin
         e   = 64'(8 * k);
         oct = (e / ENTRIES) & 64'd7;
         rem = e % ENTRIES;
         q   = oct & 64'd3;
         if (q[0]) begin
            rem = ENTRIES - rem;
         end
         t = (QUARTER_PI_Q62 / ENTRIES) * rem
           + ((QUARTER_PI_Q62 % ENTRIES) * rem) / ENTRIES;
         use_cos = (q == 64'd1) || (q == 64'd2);
         v = (series_q62(t, use_cos) + 64'h40000000) >> 31;
         if (v > 64'h7FFFFFFF) begin
            v = 64'h7FFFFFFF;
         end
         if (oct >= 64'd4) begin
            v = 64'd0;
         end
         rom[k] = v[svpd_pkg::Q31_W-1:0];
      end
      return rom;
   endfunction

   localparam rom_array_type ROM_CONTENTS = build_rom();

   logic [ADDR_W-1:0]           addr_next;
   logic [svpd_pkg::Q31_W-1:0]  data_lo_ff;
   logic [svpd_pkg::Q31_W-1:0]  data_hi_ff;

   assign addr_next = addr + 1'b1;
   assign data_lo   = data_lo_ff;
   assign data_hi   = data_hi_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         data_lo_ff <= ROM_CONTENTS[addr];
         data_hi_ff <= ROM_CONTENTS[addr_next];
      end
   end

endmodule

FILE: design/svpd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpd_back
// Six-stage datapath: table index, table read, interpolation, sine, vector
// times, duty routing into the output register.
// ----------------------------------------------------------------------------
module svpd_back #(
   parameter int SINE_TABLE_ENTRIES = svpd_pkg::SINE_TABLE_ENTRIES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   input  svpd_pkg::svpd_job_type      job,
   output logic                        job_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [svpd_pkg::Q31_W-1:0]  rsp_duty_u,
   output logic [svpd_pkg::Q31_W-1:0]  rsp_duty_v,
   output logic [svpd_pkg::Q31_W-1:0]  rsp_duty_w
);

   localparam int Q     = svpd_pkg::Q31_W;
   localparam int XW    = svpd_pkg::ARG_W;
   localparam int ROM_DEPTH = svpd_pkg::rom_depth(SINE_TABLE_ENTRIES);
   localparam int ADDR_W    = $clog2(ROM_DEPTH);
   localparam int NW    = $clog2(SINE_TABLE_ENTRIES + 1);
   localparam int PW    = XW + NW;

   logic enable;

   // stage 1: table index and fraction
   logic                         valid_s1_ff;
   svpd_pkg::svpd_sector_type    sector_s1_ff;
   logic [Q-1:0]                 scale_s1_ff;
   logic [ADDR_W-1:0]            idx_a_s1_ff, idx_a_s1_in;
   logic [ADDR_W-1:0]            idx_b_s1_ff, idx_b_s1_in;
   logic [Q-1:0]                 frac_a_s1_ff, frac_a_s1_in;
   logic [Q-1:0]                 frac_b_s1_ff, frac_b_s1_in;
   logic [PW-1:0]                pos_a, pos_b;

   // stage 2: table rows
   logic                         valid_s2_ff;
   svpd_pkg::svpd_sector_type    sector_s2_ff;
   logic [Q-1:0]                 scale_s2_ff;
   logic [Q-1:0]                 frac_a_s2_ff, frac_b_s2_ff;
   logic [Q-1:0]                 row_a_lo, row_a_hi, row_b_lo, row_b_hi;

   // stage 3: interpolation products
   logic                         valid_s3_ff;
   svpd_pkg::svpd_sector_type    sector_s3_ff;
   logic [Q-1:0]                 scale_s3_ff;
   logic [Q-1:0]                 lo_a_s3_ff, lo_a_s3_in, lo_b_s3_ff, lo_b_s3_in;
   logic [Q-2:0]                 hi_a_s3_ff, hi_a_s3_in, hi_b_s3_ff, hi_b_s3_in;
   logic [Q:0]                   weight_a, weight_b;
   logic [2*Q:0]                 prod_lo_a, prod_lo_b;
   logic [2*Q-1:0]               prod_hi_a, prod_hi_b;

   // stage 4: sines
   logic                         valid_s4_ff;
   svpd_pkg::svpd_sector_type    sector_s4_ff;
   logic [Q-1:0]                 scale_s4_ff;
   logic [Q-1:0]                 sine_a_s4_ff, sine_a_s4_in, sine_b_s4_ff, sine_b_s4_in;
   logic [Q:0]                   sum_a, sum_b;

   // stage 5: vector times
   logic                         valid_s5_ff;
   svpd_pkg::svpd_sector_type    sector_s5_ff;
   logic [Q-1:0]                 time_a_s5_ff, time_a_s5_in, time_b_s5_ff, time_b_s5_in;
   logic [2*Q-1:0]               prod_t_a, prod_t_b;

   // stage 6: output register
   logic                         rsp_valid_ff;
   logic [Q-1:0]                 duty_u_ff, duty_u_in;
   logic [Q-1:0]                 duty_v_ff, duty_v_in;
   logic [Q-1:0]                 duty_w_ff, duty_w_in;
   logic [Q-1:0]                 half_a, half_b;
   logic [Q-1:0]                 t0, t1, t2, t3;

   assign enable     = !rsp_valid_ff || rsp_ready;
   assign job_pop    = enable && job_valid;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_duty_u = duty_u_ff;
   assign rsp_duty_v = duty_v_ff;
   assign rsp_duty_w = duty_w_ff;

   svpd_sine_rom #(
      .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
   ) u_rom_a (
      .clock   (clock),
      .enable  (enable),
      .addr    (idx_a_s1_ff),
      .data_lo (row_a_lo),
      .data_hi (row_a_hi)
   );

   svpd_sine_rom #(
      .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
   ) u_rom_b (
      .clock   (clock),
      .enable  (enable),
      .addr    (idx_b_s1_ff),
      .data_lo (row_b_lo),
      .data_hi (row_b_hi)
   );

   always_comb begin
      pos_a        = {{NW{1'b0}}, job.arg_a} * PW'(SINE_TABLE_ENTRIES);
      pos_b        = {{NW{1'b0}}, job.arg_b} * PW'(SINE_TABLE_ENTRIES);
      idx_a_s1_in  = ADDR_W'(pos_a >> Q);
      idx_b_s1_in  = ADDR_W'(pos_b >> Q);
      frac_a_s1_in = pos_a[Q-1:0];
      frac_b_s1_in = pos_b[Q-1:0];

      weight_a   = {1'b1, {Q{1'b0}}} - {1'b0, frac_a_s2_ff};
      weight_b   = {1'b1, {Q{1'b0}}} - {1'b0, frac_b_s2_ff};
      prod_lo_a  = {{Q{1'b0}}, weight_a} * {{(Q+1){1'b0}}, row_a_lo};
      prod_lo_b  = {{Q{1'b0}}, weight_b} * {{(Q+1){1'b0}}, row_b_lo};
      prod_hi_a  = {{Q{1'b0}}, frac_a_s2_ff} * {{Q{1'b0}}, row_a_hi};
      prod_hi_b  = {{Q{1'b0}}, frac_b_s2_ff} * {{Q{1'b0}}, row_b_hi};
      lo_a_s3_in = prod_lo_a[2*Q:Q+1];
      lo_b_s3_in = prod_lo_b[2*Q:Q+1];
      hi_a_s3_in = prod_hi_a[2*Q-1:Q+1];
      hi_b_s3_in = prod_hi_b[2*Q-1:Q+1];

      sum_a        = {1'b0, lo_a_s3_ff} + {2'b00, hi_a_s3_ff};
      sum_b        = {1'b0, lo_b_s3_ff} + {2'b00, hi_b_s3_ff};
      sine_a_s4_in = {sum_a[Q-2:0], 1'b0};
      sine_b_s4_in = {sum_b[Q-2:0], 1'b0};

      prod_t_a     = {{Q{1'b0}}, scale_s4_ff} * {{Q{1'b0}}, sine_a_s4_ff};
      prod_t_b     = {{Q{1'b0}}, scale_s4_ff} * {{Q{1'b0}}, sine_b_s4_ff};
      time_a_s5_in = prod_t_a[2*Q-1:Q];
      time_b_s5_in = prod_t_b[2*Q-1:Q];

      half_a = time_a_s5_ff >> 1;
      half_b = time_b_s5_ff >> 1;
      t0     = svpd_pkg::HALF_Q31 - half_a - half_b;
      t1     = svpd_pkg::HALF_Q31 + half_a - half_b;
      t2     = svpd_pkg::HALF_Q31 - half_a + half_b;
      t3     = svpd_pkg::HALF_Q31 + half_a + half_b;

      case (sector_s5_ff)
         svpd_pkg::SECTOR_0: begin
            duty_u_in = t0;
            duty_v_in = t2;
            duty_w_in = t3;
         end
         svpd_pkg::SECTOR_1: begin
            duty_u_in = t0;
            duty_v_in = t3;
            duty_w_in = t1;
         end
         svpd_pkg::SECTOR_2: begin
            duty_u_in = t2;
            duty_v_in = t3;
            duty_w_in = t0;
         end
         svpd_pkg::SECTOR_3: begin
            duty_u_in = t3;
            duty_v_in = t1;
            duty_w_in = t0;
         end
         svpd_pkg::SECTOR_4: begin
            duty_u_in = t3;
            duty_v_in = t0;
            duty_w_in = t2;
         end
         default: begin
            duty_u_in = t1;
            duty_v_in = t0;
            duty_w_in = t3;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff  <= 1'b0;
         valid_s2_ff  <= 1'b0;
         valid_s3_ff  <= 1'b0;
         valid_s4_ff  <= 1'b0;
         valid_s5_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         valid_s1_ff  <= job_valid;
         valid_s2_ff  <= valid_s1_ff;
         valid_s3_ff  <= valid_s2_ff;
         valid_s4_ff  <= valid_s3_ff;
         valid_s5_ff  <= valid_s4_ff;
         rsp_valid_ff <= valid_s5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sector_s1_ff <= job.sector;
         scale_s1_ff  <= job.scale;
         idx_a_s1_ff  <= idx_a_s1_in;
         idx_b_s1_ff  <= idx_b_s1_in;
         frac_a_s1_ff <= frac_a_s1_in;
         frac_b_s1_ff <= frac_b_s1_in;

         sector_s2_ff <= sector_s1_ff;
         scale_s2_ff  <= scale_s1_ff;
         frac_a_s2_ff <= frac_a_s1_ff;
         frac_b_s2_ff <= frac_b_s1_ff;

         sector_s3_ff <= sector_s2_ff;
         scale_s3_ff  <= scale_s2_ff;
         lo_a_s3_ff   <= lo_a_s3_in;
         lo_b_s3_ff   <= lo_b_s3_in;
         hi_a_s3_ff   <= hi_a_s3_in;
         hi_b_s3_ff   <= hi_b_s3_in;

         sector_s4_ff <= sector_s3_ff;
         scale_s4_ff  <= scale_s3_ff;
         sine_a_s4_ff <= sine_a_s4_in;
         sine_b_s4_ff <= sine_b_s4_in;

         sector_s5_ff <= sector_s4_ff;
         time_a_s5_ff <= time_a_s5_in;
         time_b_s5_ff <= time_b_s5_in;

         duty_u_ff    <= duty_u_in;
         duty_v_ff    <= duty_v_in;
         duty_w_ff    <= duty_w_in;
      end
   end

endmodule
